### rtl/wip_pkg.sv
// Shared types, sizes and codes for the weighted index picker.
`default_nettype none

package wip_pkg;

  // Table size and weight precision
  localparam int MAX_ENTRIES = 256;
  localparam int WEIGHT_BITS = 32;

  // Fixed widths of the word fields
  localparam int IN_WEIGHT_BITS = 32;
  localparam int FRAC_BITS      = 32;
  localparam int STATUS_BITS    = 3;
  localparam int PICK_IDX_BITS  = 8;

  // Derived widths
  localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
  localparam int TOTAL_BITS  = WEIGHT_BITS + CNT_BITS;
  localparam int MUL_HI_BITS = (TOTAL_BITS > FRAC_BITS) ? (TOTAL_BITS - FRAC_BITS) : 1;
  localparam int SEL_BITS    = FRAC_BITS + MUL_HI_BITS;

  typedef enum logic [0:0] {
    KIND_ADD  = 1'b0,
    KIND_PICK = 1'b1
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ADDED  = 3'd0,
    ST_FULL   = 3'd1,
    ST_PICKED = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_NOHIT  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic [IN_WEIGHT_BITS-1:0] weight;
    logic [FRAC_BITS-1:0]      random_fraction;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic [PICK_IDX_BITS-1:0] picked_index;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_SEL,
    S_WALK,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic mul_lo;
    logic mul_hi;
    logic sel_load;
    logic issue;
    logic eval;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/wip_ctrl.sv
// Controller state machine for the weighted index picker.
`default_nettype none

module wip_ctrl
  import wip_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = sts.need_walk ? S_MUL_LO : S_DONE;
        end
      end
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_SEL;
      S_SEL:    state_next = S_WALK;
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = item_valid;
      end
      S_MUL_LO: cmd.mul_lo = 1'b1;
      S_MUL_HI: cmd.mul_hi = 1'b1;
      S_SEL: begin
        cmd.sel_load = 1'b1;
        cmd.issue    = 1'b1;
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        cmd.eval  = 1'b1;
      end
      S_DONE:   cmd.out_load = sts.out_free;
      default: begin
        cmd  = '0;
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/wip_dp.sv
// Datapath: weight table, running total, selector multiply, table walk, result register.
`default_nettype none

module wip_dp
  import wip_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire item_t   item,
  input  wire cmd_t    cmd,
  output sts_t         sts,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic [WEIGHT_BITS-1:0] table_mem [MAX_ENTRIES];

  logic [CNT_BITS-1:0]      count;
  logic [TOTAL_BITS-1:0]    total;
  logic [FRAC_BITS-1:0]     frac;
  logic [2*FRAC_BITS-1:0]   prod_lo;
  logic [SEL_BITS-1:0]      prod_hi;
  logic [SEL_BITS-1:0]      sel;
  logic [SEL_BITS-1:0]      accum;
  logic [CNT_BITS-1:0]      rd_ptr;
  logic [WEIGHT_BITS-1:0]   rdata;
  logic                     rdata_vld;
  logic [IDX_BITS-1:0]      rdata_idx;
  status_t                  res_status;
  logic [PICK_IDX_BITS-1:0] res_index;

  logic [SEL_BITS-1:0]    total_ext;
  logic [SEL_BITS-1:0]    accum_sum;
  logic [WEIGHT_BITS-1:0] new_weight;
  logic                   is_full;
  logic                   hit;

  assign total_ext  = SEL_BITS'(total);
  assign new_weight = WEIGHT_BITS'(item.weight);
  assign is_full    = (count == CNT_BITS'(MAX_ENTRIES));
  assign accum_sum  = accum + SEL_BITS'(rdata);
  assign hit        = rdata_vld && (sel < accum_sum);

  assign sts.need_walk = (item.kind == KIND_PICK) && (count > CNT_BITS'(1));
  assign sts.walk_done = hit || !rdata_vld;
  assign sts.out_free  = !result_valid || !result_stall;

  // Append a weight to the table on an accepted add
  always_ff @(posedge clk) begin
    if (cmd.accept && item.kind == KIND_ADD && !is_full) begin
      table_mem[count[IDX_BITS-1:0]] <= new_weight;
    end
    rdata <= table_mem[rd_ptr[IDX_BITS-1:0]];
  end

  // Track entry count and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.accept && item.kind == KIND_ADD && !is_full) begin
      count <= count + CNT_BITS'(1);
      total <= total + TOTAL_BITS'(new_weight);
    end
  end

  // Scale the fraction by the total in two partial products
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      frac <= item.random_fraction;
    end
    if (cmd.mul_lo) begin
      prod_lo <= frac * total_ext[FRAC_BITS-1:0];
    end
    if (cmd.mul_hi) begin
      prod_hi <= SEL_BITS'(frac) * SEL_BITS'(total_ext[SEL_BITS-1:FRAC_BITS]);
    end
    if (cmd.sel_load) begin
      sel <= prod_hi + SEL_BITS'(prod_lo[2*FRAC_BITS-1:FRAC_BITS]);
    end
  end

  // Walk the table: issue one read a cycle, accumulate the word that returns
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      rd_ptr <= '0;
      accum  <= '0;
    end else begin
      if (cmd.issue && rd_ptr < count) begin
        rd_ptr <= rd_ptr + CNT_BITS'(1);
      end
      if (cmd.eval && rdata_vld) begin
        accum <= accum_sum;
      end
    end
    rdata_idx <= rd_ptr[IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rdata_vld <= 1'b0;
    end else begin
      rdata_vld <= cmd.issue && (rd_ptr < count);
    end
  end

  // Settle the result of the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_index <= '0;
      if (item.kind == KIND_ADD) begin
        res_status <= is_full ? ST_FULL : ST_ADDED;
      end else if (count == '0) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_PICKED;
      end
    end else if (cmd.eval) begin
      if (hit) begin
        res_status <= ST_PICKED;
        res_index  <= PICK_IDX_BITS'(rdata_idx);
      end else if (!rdata_vld) begin
        res_status <= ST_NOHIT;
        res_index  <= '0;
      end
    end
  end

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.status       <= res_status;
      result.picked_index <= res_index;
    end
  end

endmodule

`default_nettype wire

### rtl/weighted_index_picker.sv
// Top level of the weighted index picker: roulette-wheel selection over a weight table.
//
//   channel  | valid         | stall         | word
//   ---------+---------------+---------------+------------------
//   item in  | item_valid    | item_stall    | item   (item_t)
//   result   | result_valid  | result_stall  | result (result_t)
//
// An add, or a pick on a table of zero or one entry, goes from idle straight to the done
// state. A pick on two or more entries first passes the low and high multiply states,
// the select state and the walk: the walk reads one table entry per cycle from its port.
// Reset (rst, synchronous) empties the table and zeroes the total; no clearing pass.
// A new item is taken while the previous result still waits under result_stall.
`default_nettype none

module weighted_index_picker
  import wip_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  cmd_t cmd;
  sts_t sts;
  logic busy;

  assign item_stall = busy;

  wip_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  wip_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
